// ===== rtl/abp_pkg.sv =====
package abp_pkg;

  localparam int unsigned ChanWidth = 8;
  localparam int unsigned NumColor = 3;
  localparam int unsigned PixWidth = 32;
  localparam int unsigned ProdWidth = 2 * ChanWidth;
  localparam int unsigned DiffProdWidth = ProdWidth + 1;
  localparam int unsigned AlphaLsb = NumColor * ChanWidth;
  localparam logic [ChanWidth-1:0] ChanMax = 8'hFF;
  localparam logic [ChanWidth-1:0] ChanZero = 8'h00;

  typedef enum logic [1:0] {
    BLEND_SKIP,
    BLEND_COPY,
    BLEND_OPAQUE,
    BLEND_PARTIAL
  } blend_mode_t;

  typedef struct packed {
    blend_mode_t         mode;
    logic [PixWidth-1:0] src;
    logic [PixWidth-1:0] dst;
  } decode_t;

  typedef struct packed {
    blend_mode_t                             mode;
    logic [PixWidth-1:0]                     src;
    logic [PixWidth-1:0]                     dst;
    logic [NumColor-1:0][DiffProdWidth-1:0]  diff_prod;
    logic [NumColor-1:0][ProdWidth-1:0]      src_prod;
    logic [NumColor-1:0][ProdWidth-1:0]      dst_prod;
    logic [ProdWidth-1:0]                    alpha_prod;
  } product_t;

  typedef struct packed {
    logic                write_enable;
    logic [PixWidth-1:0] pixel;
  } result_t;

endpackage

// ===== rtl/abp_decode.sv =====
module abp_decode import abp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PixWidth-1:0] src,
  input  logic [PixWidth-1:0] dst,
  output logic                out_valid,
  input  logic                out_ready,
  output decode_t             out_data
);

  logic        valid;
  decode_t     data;
  blend_mode_t mode_next;
  logic [ChanWidth-1:0] sa;
  logic [ChanWidth-1:0] da;

  assign sa = src[AlphaLsb +: ChanWidth];
  assign da = dst[AlphaLsb +: ChanWidth];

  always_comb begin
    if (sa == ChanZero) begin
      mode_next = BLEND_SKIP;
    end else if (sa == ChanMax || da == ChanZero) begin
      mode_next = BLEND_COPY;
    end else if (da == ChanMax) begin
      mode_next = BLEND_OPAQUE;
    end else begin
      mode_next = BLEND_PARTIAL;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.mode <= mode_next;
      data.src  <= src;
      data.dst  <= dst;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== rtl/abp_multiply.sv =====
module abp_multiply import abp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  decode_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output product_t out_data
);

  logic     valid;
  product_t data;
  product_t data_next;

  always_comb begin
    logic [ChanWidth-1:0] sa;
    logic [ChanWidth-1:0] da;
    logic [ChanWidth-1:0] s;
    logic [ChanWidth-1:0] d;
    logic signed [DiffProdWidth-1:0] diff;
    sa = in_data.src[AlphaLsb +: ChanWidth];
    da = in_data.dst[AlphaLsb +: ChanWidth];
    data_next.mode = in_data.mode;
    data_next.src  = in_data.src;
    data_next.dst  = in_data.dst;
    for (int i = 0; i < NumColor; i++) begin
      s = in_data.src[i*ChanWidth +: ChanWidth];
      d = in_data.dst[i*ChanWidth +: ChanWidth];
      diff = $signed({1'b0, s}) - $signed({1'b0, d});
      data_next.diff_prod[i] = diff * $signed({1'b0, sa});
      data_next.src_prod[i]  = s * sa;
      data_next.dst_prod[i]  = d * (ChanMax - sa);
    end
    data_next.alpha_prod = (ChanMax - da) * sa;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== rtl/abp_mix.sv =====
module abp_mix import abp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  product_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_data
);

  logic    valid;
  result_t data;
  result_t data_next;
  logic [NumColor-1:0][ChanWidth-1:0] opaque_chan;
  logic [NumColor-1:0][ChanWidth-1:0] partial_chan;
  logic [ChanWidth-1:0] partial_alpha;

  // The floor shift of (s - d) * a keeps only bits 15..8, which the two's
  // complement product already holds, so no offset is needed.
  always_comb begin
    logic [ProdWidth:0] t;
    logic [ProdWidth:0] r;
    for (int i = 0; i < NumColor; i++) begin
      opaque_chan[i] = in_data.diff_prod[i][ChanWidth +: ChanWidth]
                       + in_data.dst[i*ChanWidth +: ChanWidth];
      t = (ProdWidth+1)'(1) + {1'b0, in_data.src_prod[i]} + {1'b0, in_data.dst_prod[i]};
      r = t + (t >> ChanWidth);
      partial_chan[i] = r[ChanWidth +: ChanWidth];
    end
    partial_alpha = in_data.dst[AlphaLsb +: ChanWidth]
                    + in_data.alpha_prod[ChanWidth +: ChanWidth];
  end

  always_comb begin
    data_next.write_enable = 1'b1;
    unique case (in_data.mode)
      BLEND_SKIP: begin
        data_next.write_enable = 1'b0;
        data_next.pixel = in_data.dst;
      end
      BLEND_COPY: begin
        data_next.pixel = in_data.src;
      end
      BLEND_OPAQUE: begin
        data_next.pixel = {ChanMax, opaque_chan};
      end
      BLEND_PARTIAL: begin
        data_next.pixel = {partial_alpha, partial_chan};
      end
      default: begin
        data_next.pixel = in_data.dst;
      end
    endcase
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== rtl/argb_alpha_blend_pixel.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid, in_stall   source_pixel, dest_pixel
// output    out        out_valid, out_stall write_enable, blended_pixel
//
// One pixel is accepted per clock while the output is not stalled.
// The three stages are decode, channel multiplies, and final add and select.
// Reset clears the valid bit of every stage; payload registers are not reset.
// A stall on the output holds each stage that is full, and a stage that is
// empty keeps accepting, so no beat is lost or repeated.
module argb_alpha_blend_pixel import abp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PixWidth-1:0] source_pixel,
  input  logic [PixWidth-1:0] dest_pixel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                write_enable,
  output logic [PixWidth-1:0] blended_pixel
);

  logic     dec_ready;
  logic     dec_valid;
  decode_t  dec_data;
  logic     mul_ready;
  logic     mul_valid;
  product_t mul_data;
  logic     mix_ready;
  result_t  mix_data;

  abp_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (dec_ready),
    .src       (source_pixel),
    .dst       (dest_pixel),
    .out_valid (dec_valid),
    .out_ready (mul_ready),
    .out_data  (dec_data)
  );

  abp_multiply u_multiply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (mul_ready),
    .in_data   (dec_data),
    .out_valid (mul_valid),
    .out_ready (mix_ready),
    .out_data  (mul_data)
  );

  abp_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mix_ready),
    .in_data   (mul_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (mix_data)
  );

  assign in_stall      = !dec_ready;
  assign write_enable  = mix_data.write_enable;
  assign blended_pixel = mix_data.pixel;

endmodule
